// ===== hdl/mvv_pkg.sv =====
package mvv_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DW = 32;
   localparam int CW = 31;
   localparam int VW = 17;
   localparam int PW = 64;
   localparam int QW = 31;
   localparam int AW = 4;
   localparam int XW = CW + FRAC_BITS;

   typedef enum logic [1:0] {
      KIND_FIRST  = 2'd0,
      KIND_SECOND = 2'd1,
      KIND_CONC   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      REG_STEP_TIME  = 2'd0,
      REG_HALF_FORCE = 2'd1,
      REG_VERLET     = 2'd2
   } reg_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic                  in_group;
      logic [CW-1:0]         mass;
      logic [2:0][DW-1:0]    pos;
      logic [2:0][DW-1:0]    vel;
      logic [2:0][DW-1:0]    frc;
   } item_type;

   typedef struct packed {
      logic [CW-1:0] step_time;
      logic [CW-1:0] half_force_scale;
      logic [VW-1:0] verlet_factor;
   } cfg_type;

   function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] x);
      logic signed [PW-1:0] hi;
      logic signed [PW-1:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (x > hi) begin
         sat32 = hi[DW-1:0];
      end else if (x < lo) begin
         sat32 = lo[DW-1:0];
      end else begin
         sat32 = x[DW-1:0];
      end
   endfunction

   function automatic logic signed [PW-1:0] smul(input logic [CW-1:0] a,
                                                 input logic [DW-1:0] b);
      logic signed [PW-1:0] ae;
      logic signed [PW-1:0] be;
      ae = PW'($signed({1'b0, a}));
      be = PW'($signed(b));
      smul = ae * be;
   endfunction

   function automatic logic signed [DW-1:0] add_shift(input logic [DW-1:0] v,
                                                      input logic signed [PW-1:0] p,
                                                      input int unsigned sh);
      logic signed [PW-1:0] ve;
      ve = PW'($signed(v));
      add_shift = sat32(ve + (p >>> sh));
   endfunction

endpackage

// ===== hdl/mvv_if.sv =====
interface mvv_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        in_group;
   logic [30:0] mass;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic signed [31:0] frc_x;
   logic signed [31:0] frc_y;
   logic signed [31:0] frc_z;

   modport source(output valid, kind, in_group, mass, pos_x, pos_y, pos_z,
                  vel_x, vel_y, vel_z, frc_x, frc_y, frc_z, input ready);
   modport sink(input valid, kind, in_group, mass, pos_x, pos_y, pos_z,
                vel_x, vel_y, vel_z, frc_x, frc_y, frc_z, output ready);
endinterface

interface mvv_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] new_pos_x;
   logic signed [31:0] new_pos_y;
   logic signed [31:0] new_pos_z;
   logic signed [31:0] new_vel_x;
   logic signed [31:0] new_vel_y;
   logic signed [31:0] new_vel_z;
   logic signed [31:0] est_vel_x;
   logic signed [31:0] est_vel_y;
   logic signed [31:0] est_vel_z;

   modport source(output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x,
                  new_vel_y, new_vel_z, est_vel_x, est_vel_y, est_vel_z, input ready);
   modport sink(input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x,
                new_vel_y, new_vel_z, est_vel_x, est_vel_y, est_vel_z, output ready);
endinterface

// ===== hdl/mvv_csr.sv =====
module mvv_csr import mvv_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           psel,
   input  logic           penable,
   input  logic           pwrite,
   input  logic [AW-1:0]  paddr,
   input  logic [31:0]    pwdata,
   output logic [31:0]    prdata,
   output logic           pready,
   output cfg_type        cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr;
   reg_type idx;

   assign idx    = reg_type'(paddr[3:2]);
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_STEP_TIME:  cfg_in.step_time        = pwdata[CW-1:0];
            REG_HALF_FORCE: cfg_in.half_force_scale = pwdata[CW-1:0];
            REG_VERLET:     cfg_in.verlet_factor    = pwdata[VW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_STEP_TIME:  prdata = {1'b0, cfg_ff.step_time};
         REG_HALF_FORCE: prdata = {1'b0, cfg_ff.half_force_scale};
         REG_VERLET:     prdata = {{(32-VW){1'b0}}, cfg_ff.verlet_factor};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_time        <= CW'(328);
         cfg_ff.half_force_scale <= CW'(164);
         cfg_ff.verlet_factor    <= VW'(32768);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/mvv_gain.sv =====
module mvv_gain import mvv_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           in_valid,
   output logic           in_ready,
   input  item_type       in_item,
   output logic           out_valid,
   input  logic           out_ready,
   output item_type       out_item,
   output logic [CW-1:0]  out_gain
);

   localparam int NS = QW + 1;

   logic [NS-1:0]   v_ff;
   logic [NS-1:0]   en;
   item_type        item_ff [NS];
   logic [CW-1:0]   rem_ff  [NS];
   logic [QW-1:0]   q_ff    [NS];
   logic            ovf_ff  [NS];
   logic [XW-1:0]   dvd;
   logic [FRAC_BITS-1:0] rem0;
   logic [CW-1:0]   mass0;
   item_type        item0;

   assign dvd  = {cfg.half_force_scale, {FRAC_BITS{1'b0}}};
   assign rem0 = dvd[XW-1:QW];

   always_comb begin
      mass0 = in_item.mass;
      if (in_item.mass == '0) begin
         mass0 = CW'(1);
      end
      item0      = in_item;
      item0.mass = mass0;
   end

   always_comb begin
      en[NS-1] = !v_ff[NS-1] | out_ready;
      for (int s = NS - 2; s >= 0; s--) begin
         en[s] = !v_ff[s] | en[s+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NS-1];
   assign out_item  = item_ff[NS-1];
   assign out_gain  = ovf_ff[NS-1] ? {CW{1'b1}} : q_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en[0]) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         item_ff[0] <= item0;
         rem_ff[0]  <= {{(CW-FRAC_BITS){1'b0}}, rem0};
         q_ff[0]    <= '0;
         ovf_ff[0]  <= {{(CW-FRAC_BITS){1'b0}}, rem0} >= mass0;
      end
   end

   for (genvar s = 0; s < QW; s++) begin : g_div
      logic [CW:0] t;
      logic [CW:0] diff;
      logic        ge;

      assign t    = {rem_ff[s], dvd[QW-1-s]};
      assign ge   = t >= {1'b0, item_ff[s].mass};
      assign diff = t - {1'b0, item_ff[s].mass};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (en[s+1]) begin
            v_ff[s+1] <= v_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en[s+1]) begin
            item_ff[s+1] <= item_ff[s];
            rem_ff[s+1]  <= ge ? diff[CW-1:0] : t[CW-1:0];
            q_ff[s+1]    <= {q_ff[s][QW-2:0], ge};
            ovf_ff[s+1]  <= ovf_ff[s];
         end
      end
   end

endmodule

// ===== hdl/mvv_update.sv =====
module mvv_update import mvv_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           in_valid,
   output logic           in_ready,
   input  item_type       in_item,
   input  logic [CW-1:0]  in_gain,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [2:0][DW-1:0] out_pos,
   output logic [2:0][DW-1:0] out_vel,
   output logic [2:0][DW-1:0] out_est
);

   localparam int NS = 5;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   item_type               item1_ff, item2_ff, item3_ff, item4_ff;
   logic [CW-1:0]          k1_ff;
   logic [47:0]            kwp1_ff;
   logic signed [PW-1:0]   kf2_ff  [3];
   logic signed [PW-1:0]   kwf2_ff [3];
   logic [2:0][DW-1:0]     est3_ff, nv3_ff, est4_ff, nv4_ff;
   logic [DW-1:0]          conc3_ff, conc4_ff;
   logic signed [PW-1:0]   ep4_ff  [3];
   logic [2:0][DW-1:0]     pos5_ff, vel5_ff, est5_ff;

   logic [47:0]            kwsh;
   logic [CW-1:0]          kw;
   logic [CW-1:0]          ax;
   logic [2:0][DW-1:0]     pos_in, vel_in, est_in;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] | out_ready;
      for (int s = NS - 2; s >= 0; s--) begin
         en[s] = !v_ff[s] | en[s+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NS-1];
   assign out_pos   = pos5_ff;
   assign out_vel   = vel5_ff;
   assign out_est   = est5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int s = 1; s < NS; s++) begin
            if (en[s]) begin
               v_ff[s] <= v_ff[s-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         item1_ff <= in_item;
         k1_ff    <= in_gain;
         kwp1_ff  <= 48'(cfg.verlet_factor) * 48'(in_gain);
      end
   end

   assign kwsh = kwp1_ff >> (FRAC_BITS - 1);
   assign kw   = (kwsh[47:CW] != '0) ? {CW{1'b1}} : kwsh[CW-1:0];
   assign ax   = (item1_ff.kind == KIND_CONC) ? cfg.step_time : k1_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         item2_ff   <= item1_ff;
         kf2_ff[0]  <= smul(ax, item1_ff.frc[0]);
         kwf2_ff[0] <= smul(kw, item1_ff.frc[0]);
         for (int i = 1; i < 3; i++) begin
            kf2_ff[i]  <= smul(k1_ff, item1_ff.frc[i]);
            kwf2_ff[i] <= smul(kw, item1_ff.frc[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         item3_ff <= item2_ff;
         for (int i = 0; i < 3; i++) begin
            est3_ff[i] <= add_shift(item2_ff.vel[i], kf2_ff[i], FRAC_BITS);
            nv3_ff[i]  <= add_shift(item2_ff.vel[i], kwf2_ff[i], FRAC_BITS);
         end
         conc3_ff <= add_shift(item2_ff.pos[0], kf2_ff[0], FRAC_BITS + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         item4_ff <= item3_ff;
         est4_ff  <= est3_ff;
         nv4_ff   <= nv3_ff;
         conc4_ff <= conc3_ff;
         for (int i = 0; i < 3; i++) begin
            ep4_ff[i] <= smul(cfg.step_time, est3_ff[i]);
         end
      end
   end

   always_comb begin
      pos_in = item4_ff.pos;
      vel_in = item4_ff.vel;
      est_in = '0;
      if (item4_ff.in_group) begin
         unique case (item4_ff.kind)
            KIND_FIRST: begin
               for (int i = 0; i < 3; i++) begin
                  pos_in[i] = add_shift(item4_ff.pos[i], ep4_ff[i], FRAC_BITS);
               end
               vel_in = nv4_ff;
               est_in = est4_ff;
            end
            KIND_SECOND: vel_in = est4_ff;
            KIND_CONC:   pos_in[0] = conc4_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         pos5_ff <= pos_in;
         vel5_ff <= vel_in;
         est5_ff <= est_in;
      end
   end

endmodule

// ===== hdl/modified_velocity_verlet_step.sv =====
// Channel  Dir  Handshake    Payload
// req      in   valid/ready  kind, in_group, mass, pos_*, vel_*, frc_*
// rsp      out  valid/ready  new_pos_*, new_vel_*, est_vel_*
// csr      in   APB          step_time, half_force_scale, verlet_factor
//
// One item per cycle while rsp is not stalled; each item passes through the
// one-bit-per-stage gain divider, then the multiply, add and saturate stages.
// Synchronous active-high reset clears valid bits and loads register defaults.
// A stall at rsp backs up stage by stage; empty stages keep taking items.
module modified_velocity_verlet_step import mvv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   mvv_req_if.sink       req,
   mvv_rsp_if.source     rsp,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [AW-1:0] paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);

   cfg_type            cfg;
   item_type           in_item;
   item_type           g_item;
   logic [CW-1:0]      g_gain;
   logic               g_valid;
   logic               g_ready;
   logic [2:0][DW-1:0] pos, vel, est;

   assign in_item.kind     = req.kind;
   assign in_item.in_group = req.in_group;
   assign in_item.mass     = req.mass;
   assign in_item.pos      = {req.pos_z, req.pos_y, req.pos_x};
   assign in_item.vel      = {req.vel_z, req.vel_y, req.vel_x};
   assign in_item.frc      = {req.frc_z, req.frc_y, req.frc_x};

   mvv_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready), .cfg(cfg)
   );

   mvv_gain u_gain (
      .clock(clock), .reset(reset), .cfg(cfg),
      .in_valid(req.valid), .in_ready(req.ready), .in_item(in_item),
      .out_valid(g_valid), .out_ready(g_ready), .out_item(g_item), .out_gain(g_gain)
   );

   mvv_update u_update (
      .clock(clock), .reset(reset), .cfg(cfg),
      .in_valid(g_valid), .in_ready(g_ready), .in_item(g_item), .in_gain(g_gain),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_pos(pos), .out_vel(vel), .out_est(est)
   );

   assign rsp.new_pos_x = pos[0];
   assign rsp.new_pos_y = pos[1];
   assign rsp.new_pos_z = pos[2];
   assign rsp.new_vel_x = vel[0];
   assign rsp.new_vel_y = vel[1];
   assign rsp.new_vel_z = vel[2];
   assign rsp.est_vel_x = est[0];
   assign rsp.est_vel_y = est[1];
   assign rsp.est_vel_z = est[2];

endmodule

// ===== tb/sv/tb_modified_velocity_verlet_step.sv =====
`timescale 1ns / 100ps

module tb_modified_velocity_verlet_step;
   import mvv_pkg::*;

   typedef struct {
      logic [DW-1:0] npos [3];
      logic [DW-1:0] nvel [3];
      logic [DW-1:0] est [3];
   } motion_type;

   typedef struct {
      logic [1:0]    kind;
      logic          grp;
      logic [CW-1:0] mass;
      logic [DW-1:0] pos [3];
      logic [DW-1:0] vel [3];
      logic [DW-1:0] frc [3];
      logic          typed;
      motion_type    want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   mvv_req_if req();
   mvv_rsp_if rsp();

   modified_velocity_verlet_step dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [CW-1:0] step_time_q;
   logic [CW-1:0] half_force_q;
   logic [VW-1:0] verlet_q;
   motion_type    pending_q [$];
   int            errors = 0;
   bit            stall_rsp = 1'b0;

   initial begin
      #4000000;
      $display("** modified_velocity_verlet_step: FAILED **");
      $finish;
   end

   function automatic logic signed [63:0] floor_sh(input logic signed [63:0] x, input int s);
      floor_sh = x >>> s;
   endfunction

   function automatic logic [DW-1:0] clamp32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) clamp32 = 32'h7FFFFFFF;
      else if (x < -64'sd2147483648) clamp32 = 32'h80000000;
      else clamp32 = x[31:0];
   endfunction

   function automatic motion_type integrate(input row_type r);
      motion_type m;
      logic [63:0] mass_e;
      logic [63:0] gain;
      logic [63:0] wgain;
      logic signed [63:0] v;
      logic signed [63:0] p;
      logic signed [63:0] f;
      logic signed [63:0] e;
      mass_e = (r.mass == 0) ? 64'd1 : 64'(r.mass);
      gain = (64'(half_force_q) << FRAC_BITS) / mass_e;
      if (gain > 64'h7FFFFFFF) gain = 64'h7FFFFFFF;
      wgain = (64'd2 * 64'(verlet_q) * gain) >> FRAC_BITS;
      if (wgain > 64'h7FFFFFFF) wgain = 64'h7FFFFFFF;
      for (int i = 0; i < 3; i++) begin
         m.npos[i] = r.pos[i];
         m.nvel[i] = r.vel[i];
         m.est[i] = '0;
      end
      if (r.grp) begin
         for (int i = 0; i < 3; i++) begin
            v = 64'($signed(r.vel[i]));
            p = 64'($signed(r.pos[i]));
            f = 64'($signed(r.frc[i]));
            if (r.kind == KIND_FIRST) begin
               m.est[i] = clamp32(v + floor_sh($signed(gain) * f, FRAC_BITS));
               e = 64'($signed(m.est[i]));
               m.npos[i] = clamp32(p + floor_sh($signed(64'(step_time_q)) * e, FRAC_BITS));
               m.nvel[i] = clamp32(v + floor_sh($signed(wgain) * f, FRAC_BITS));
            end else if (r.kind == KIND_SECOND) begin
               m.nvel[i] = clamp32(v + floor_sh($signed(gain) * f, FRAC_BITS));
            end else if (r.kind == KIND_CONC && i == 0) begin
               m.npos[0] = clamp32(p + floor_sh($signed(64'(step_time_q)) * f,
                                                FRAC_BITS + 1));
            end
         end
      end
      return m;
   endfunction

   task automatic csr_write(input reg_type idx, input logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= AW'(4 * int'(idx)); pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_STEP_TIME:  step_time_q = val[CW-1:0];
         REG_HALF_FORCE: half_force_q = val[CW-1:0];
         default:        verlet_q = val[VW-1:0];
      endcase
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (pending_q.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic send(input row_type r);
      r.want = r.typed ? r.want : integrate(r);
      req.valid <= 1'b1;
      req.kind <= r.kind; req.in_group <= r.grp; req.mass <= r.mass;
      req.pos_x <= r.pos[0]; req.pos_y <= r.pos[1]; req.pos_z <= r.pos[2];
      req.vel_x <= r.vel[0]; req.vel_y <= r.vel[1]; req.vel_z <= r.vel[2];
      req.frc_x <= r.frc[0]; req.frc_y <= r.frc[1]; req.frc_z <= r.frc[2];
      do @(posedge clock); while (!req.ready);
      pending_q.push_back(r.want);
   endtask

   function automatic logic [DW-1:0] rnd32();
      case ($urandom_range(0, 5))
         0: rnd32 = 32'h7FFFFFFF;
         1: rnd32 = 32'h80000000;
         2: rnd32 = $urandom_range(0, 65536 * 4);
         3: rnd32 = -$urandom_range(0, 65536 * 4);
         default: rnd32 = $urandom;
      endcase
   endfunction

   function automatic row_type random_row();
      row_type r;
      r.kind = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      r.grp = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 4))
         0: r.mass = '0;
         1: r.mass = 31'h7FFFFFFF;
         2: r.mass = 31'($urandom_range(1, 65536 * 64));
         default: r.mass = 31'($urandom);
      endcase
      for (int i = 0; i < 3; i++) begin
         r.pos[i] = rnd32(); r.vel[i] = rnd32(); r.frc[i] = rnd32();
      end
      r.typed = 1'b0;
      return r;
   endfunction

   function automatic row_type mk(input logic [1:0] kind, input logic grp,
                                  input logic [CW-1:0] mass, input logic [DW-1:0] p,
                                  input logic [DW-1:0] v, input logic [DW-1:0] f);
      row_type r;
      r.kind = kind; r.grp = grp; r.mass = mass; r.typed = 1'b0;
      for (int i = 0; i < 3; i++) begin
         r.pos[i] = p; r.vel[i] = v; r.frc[i] = f;
         r.want.npos[i] = p; r.want.nvel[i] = v; r.want.est[i] = '0;
      end
      return r;
   endfunction

   row_type stim_tab [$];

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pending_q.size() == 0) begin
               $display("%0t: unexpected item", $time);
               errors++;
            end else begin
               motion_type w;
               logic [DW-1:0] got [9];
               logic [DW-1:0] exp9 [9];
               w = pending_q.pop_front();
               got = '{rsp.new_pos_x, rsp.new_pos_y, rsp.new_pos_z, rsp.new_vel_x,
                       rsp.new_vel_y, rsp.new_vel_z, rsp.est_vel_x, rsp.est_vel_y,
                       rsp.est_vel_z};
               for (int i = 0; i < 3; i++) begin
                  exp9[i] = w.npos[i]; exp9[3 + i] = w.nvel[i]; exp9[6 + i] = w.est[i];
               end
               for (int i = 0; i < 9; i++) begin
                  if (got[i] !== exp9[i]) begin
                     $display("%0t: field %0d expected %h actual %h", $time, i,
                              exp9[i], got[i]);
                     errors++;
                  end
               end
            end
         end
         if ($urandom_range(0, 15) == 0) stall_rsp = !stall_rsp;
         rsp.ready <= stall_rsp ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   initial begin
      row_type r;
      int burst;
      req.valid = 1'b0;
      req.kind = '0; req.in_group = 1'b0; req.mass = '0;
      req.pos_x = '0; req.pos_y = '0; req.pos_z = '0;
      req.vel_x = '0; req.vel_y = '0; req.vel_z = '0;
      req.frc_x = '0; req.frc_y = '0; req.frc_z = '0;
      step_time_q = 31'd328; half_force_q = 31'd164; verlet_q = 17'd32768;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      r = mk(KIND_FIRST, 1'b0, 31'd65536, 32'h7FFFFFFF, 32'h80000000, 32'h12345678);
      r.typed = 1'b1; stim_tab.push_back(r);
      r = mk(2'd3, 1'b1, 31'd65536, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
      r.typed = 1'b1; stim_tab.push_back(r);
      r = mk(KIND_SECOND, 1'b1, 31'd65536, 32'h00010000, 32'h00020000, 32'h0);
      r.typed = 1'b1; stim_tab.push_back(r);
      stim_tab.push_back(mk(KIND_FIRST, 1'b1, 31'd65536, 32'h00010000, 32'h00010000,
                            32'h00010000));
      stim_tab.push_back(mk(KIND_FIRST, 1'b1, 31'd0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                            32'h7FFFFFFF));
      stim_tab.push_back(mk(KIND_FIRST, 1'b1, 31'd0, 32'h80000000, 32'h80000000,
                            32'h80000000));
      stim_tab.push_back(mk(KIND_FIRST, 1'b1, 31'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                            32'hFFFFFFFF));
      stim_tab.push_back(mk(KIND_SECOND, 1'b1, 31'd1, 32'h5, 32'h7FFFFFF0, 32'h7FFFFFFF));
      stim_tab.push_back(mk(KIND_SECOND, 1'b1, 31'd32768, 32'h5, 32'h80000010, 32'hFFFF0000));
      stim_tab.push_back(mk(KIND_CONC, 1'b1, 31'd0, 32'h7FFFFFFF, 32'h1, 32'h7FFFFFFF));
      stim_tab.push_back(mk(KIND_CONC, 1'b1, 31'd9, 32'h80000000, 32'h2, 32'h80000000));
      stim_tab.push_back(mk(KIND_CONC, 1'b1, 31'd9, 32'h00030000, 32'h2, 32'hFFFFFFFF));
      stim_tab.push_back(mk(KIND_CONC, 1'b0, 31'd9, 32'h00030000, 32'h2, 32'h00050000));
      foreach (stim_tab[i]) send(stim_tab[i]);
      req.valid <= 1'b0;
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               csr_write(REG_STEP_TIME, 32'h7FFFFFFF);
               csr_write(REG_HALF_FORCE, 32'h7FFFFFFF);
               csr_write(REG_VERLET, 32'd65536);
            end
            1: begin
               csr_write(REG_STEP_TIME, 32'd0);
               csr_write(REG_HALF_FORCE, 32'd0);
               csr_write(REG_VERLET, 32'd0);
            end
            2: begin
               csr_write(REG_STEP_TIME, $urandom_range(1, 65536 * 2));
               csr_write(REG_HALF_FORCE, $urandom_range(1, 65536 * 2));
               csr_write(REG_VERLET, $urandom_range(0, 65536));
            end
            default: begin
               csr_write(REG_STEP_TIME, 32'd328);
               csr_write(REG_HALF_FORCE, 32'd164);
               csr_write(REG_VERLET, 32'd32768);
            end
         endcase
         burst = 0;
         for (int n = 0; n < 110; n++) begin
            if (n == 55) begin
               req.valid <= 1'b0;
               drain();
            end else if (burst == 0) begin
               burst = $urandom_range(1, 20);
               if ($urandom_range(0, 1)) begin
                  req.valid <= 1'b0;
                  repeat ($urandom_range(1, 6)) @(posedge clock);
               end
            end
            send(random_row());
            burst--;
         end
         req.valid <= 1'b0;
         drain();
      end

      if (pending_q.size() == 0 && errors == 0) begin
         $display("** modified_velocity_verlet_step: PASSED **");
      end else begin
         $display("** modified_velocity_verlet_step: FAILED **");
      end
      $finish;
   end
endmodule
